// File: src/rtnh_pkg.sv
// ----------------------------------------------------------------------------
// rtnh_pkg: shared types and constants for the nearest ray-triangle hit block
// Holds the datapath widths, the sequencer state type and the step table that
// drives the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rtnh_pkg;

  localparam int unsigned CoordW   = 32;           // Q16.16 coordinate
  localparam int unsigned EdgeW    = CoordW + 1;   // difference of two coords
  localparam int unsigned OpAW     = EdgeW + 1;    // short operand, room to negate
  localparam int unsigned OpBW     = 68;           // long operand (cross terms)
  localparam int unsigned AccW     = 102;          // dot product accumulator
  localparam int unsigned DigitW   = 16;           // long operand digit
  localparam int unsigned MacDigits = 5;           // digits per long operand
  localparam int unsigned OpBExtW  = DigitW * MacDigits;
  localparam int unsigned ProdW    = OpAW + DigitW + 1;
  localparam int unsigned EpsW     = 16;
  localparam int unsigned QuoW     = 32;
  localparam int unsigned NumHiW   = AccW - 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned StepW    = 5;
  localparam int unsigned NumSteps = 24;
  localparam int unsigned ItemW    = 9 * CoordW;

  localparam logic [StepW-1:0] LastStep = StepW'(NumSteps - 1);

  localparam logic signed [CoordW-1:0] T32Min = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [CoordW-1:0] T32Max = {1'b0, {(CoordW-1){1'b1}}};

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X  = 3'd0,
    CFG_ORIGIN_Y  = 3'd1,
    CFG_ORIGIN_Z  = 3'd2,
    CFG_DIR_X     = 3'd3,
    CFG_DIR_Y     = 3'd4,
    CFG_DIR_Z     = 3'd5,
    CFG_EPSILON   = 3'd6,
    CFG_UNUSED    = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    VEC_D,
    VEC_E1,
    VEC_E2,
    VEC_S,
    VEC_R,
    VEC_Q
  } vec_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_R,
    DST_Q,
    DST_DET,
    DST_U,
    DST_V,
    DST_TN
  } dst_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC_ISSUE,
    ST_MAC_WAIT,
    ST_DECIDE,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    vec_e       a_vec;
    logic [1:0] a_idx;
    vec_e       b_vec;
    logic [1:0] b_idx;
    logic       sub;
    logic       first;
    dst_e       dst;
    logic [1:0] dst_idx;
  } step_t;

  // Control bundle from the sequencer to the shared MAC.
  typedef struct packed {
    logic start;
    logic first;
    logic sub;
  } mac_ctl_t;

  function automatic step_t mk_step(input vec_e av, input logic [1:0] ai,
                                    input vec_e bv, input logic [1:0] bi,
                                    input logic sb, input logic fs,
                                    input dst_e dv, input logic [1:0] di);
    step_t s;
    s.a_vec   = av;
    s.a_idx   = ai;
    s.b_vec   = bv;
    s.b_idx   = bi;
    s.sub     = sb;
    s.first   = fs;
    s.dst     = dv;
    s.dst_idx = di;
    return s;
  endfunction

  // r = d x e2, q = s x e1, then det = e1.r, u = s.r, v = d.q, tn = e2.q
  function automatic step_t step_info(input logic [StepW-1:0] idx);
    step_t s;
    case (idx)
      5'd0:  s = mk_step(VEC_D,  2'd1, VEC_E2, 2'd2, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd1:  s = mk_step(VEC_D,  2'd2, VEC_E2, 2'd1, 1'b1, 1'b0, DST_R,    2'd0);
      5'd2:  s = mk_step(VEC_D,  2'd2, VEC_E2, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd3:  s = mk_step(VEC_D,  2'd0, VEC_E2, 2'd2, 1'b1, 1'b0, DST_R,    2'd1);
      5'd4:  s = mk_step(VEC_D,  2'd0, VEC_E2, 2'd1, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd5:  s = mk_step(VEC_D,  2'd1, VEC_E2, 2'd0, 1'b1, 1'b0, DST_R,    2'd2);
      5'd6:  s = mk_step(VEC_S,  2'd1, VEC_E1, 2'd2, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd7:  s = mk_step(VEC_S,  2'd2, VEC_E1, 2'd1, 1'b1, 1'b0, DST_Q,    2'd0);
      5'd8:  s = mk_step(VEC_S,  2'd2, VEC_E1, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd9:  s = mk_step(VEC_S,  2'd0, VEC_E1, 2'd2, 1'b1, 1'b0, DST_Q,    2'd1);
      5'd10: s = mk_step(VEC_S,  2'd0, VEC_E1, 2'd1, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd11: s = mk_step(VEC_S,  2'd1, VEC_E1, 2'd0, 1'b1, 1'b0, DST_Q,    2'd2);
      5'd12: s = mk_step(VEC_E1, 2'd0, VEC_R,  2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd13: s = mk_step(VEC_E1, 2'd1, VEC_R,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd14: s = mk_step(VEC_E1, 2'd2, VEC_R,  2'd2, 1'b0, 1'b0, DST_DET,  2'd0);
      5'd15: s = mk_step(VEC_S,  2'd0, VEC_R,  2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd16: s = mk_step(VEC_S,  2'd1, VEC_R,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd17: s = mk_step(VEC_S,  2'd2, VEC_R,  2'd2, 1'b0, 1'b0, DST_U,    2'd0);
      5'd18: s = mk_step(VEC_D,  2'd0, VEC_Q,  2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd19: s = mk_step(VEC_D,  2'd1, VEC_Q,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd20: s = mk_step(VEC_D,  2'd2, VEC_Q,  2'd2, 1'b0, 1'b0, DST_V,    2'd0);
      5'd21: s = mk_step(VEC_E2, 2'd0, VEC_Q,  2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
      5'd22: s = mk_step(VEC_E2, 2'd1, VEC_Q,  2'd1, 1'b0, 1'b0, DST_NONE, 2'd0);
      5'd23: s = mk_step(VEC_E2, 2'd2, VEC_Q,  2'd2, 1'b0, 1'b0, DST_TN,   2'd0);
      default: s = mk_step(VEC_D, 2'd0, VEC_E1, 2'd0, 1'b0, 1'b1, DST_NONE, 2'd0);
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: src/ray_triangle_nearest_hit.sv
// Each triangle runs 24 MAC steps on the shared digit-serial multiplier, then
// a decide step, the divider for a hit (a miss skips the divider), an update
// step and, for a final triangle, an emit step that waits out any output stall.
// One triangle is in flight at a time: the next is taken only once the block
// is back in idle after the update or the emit.
// Reset clears the ray to origin 0, direction (1.0, 0, 0), epsilon 7, no hit.
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit: nearest Moller-Trumbore hit over a triangle stream
// Sequences one shared MAC and one divider per triangle, keeps the nearest
// nonzero distance and reports it on the last triangle of a run.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_nearest_hit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rtnh_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [rtnh_pkg::CoordW-1:0]       cfg_data_i,
  // triangle stream
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: corner_a_x, corner_a_y, corner_a_z, corner_b_x, corner_b_y,
  //        corner_b_z, corner_c_x, corner_c_y, corner_c_z (32 bits each)
  input  wire logic [rtnh_pkg::ItemW-1:0]        s_axis_tdata_i,
  input  wire logic                              s_axis_tlast_i,   // final_triangle
  // result stream
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // tdata: negated_distance (32 bits)
  output logic [rtnh_pkg::CoordW-1:0]            m_axis_tdata_o,
  // tuser: hit_found (1 bit)
  output logic                                   m_axis_tuser_o
);

  localparam int unsigned CW = rtnh_pkg::CoordW;
  localparam int unsigned EW = rtnh_pkg::EdgeW;
  localparam int unsigned AW = rtnh_pkg::AccW;

  rtnh_pkg::state_e state_q, state_d;

  // Ray registers
  logic [CW-1:0]                 org_q [3];
  logic [CW-1:0]                 dir_q [3];
  logic [rtnh_pkg::EpsW-1:0]     eps_q;

  // Per-triangle operands and results
  logic signed [EW-1:0]          e1_q [3];
  logic signed [EW-1:0]          e2_q [3];
  logic signed [EW-1:0]          s_q  [3];
  logic signed [rtnh_pkg::OpBW-1:0] r_q [3];
  logic signed [rtnh_pkg::OpBW-1:0] q_q [3];
  logic signed [AW-1:0]          det_q, u_q, v_q, tn_q;
  logic                          final_q;
  logic                          hit_q;
  logic                          negq_q;
  logic [rtnh_pkg::StepW-1:0]    step_q;

  logic signed [CW-1:0]          nearest_q;

  logic                          out_valid_q;
  logic                          out_hit_q;
  logic [CW-1:0]                 out_dist_q;

  // Sequencer outputs
  logic                          load_item;
  logic                          mac_issue;
  logic                          mac_capture;
  logic                          div_start;
  logic                          do_update;
  logic                          do_emit;
  logic                          out_free;

  rtnh_pkg::step_t               step;
  rtnh_pkg::mac_ctl_t            mac_ctl;
  logic signed [rtnh_pkg::OpAW-1:0] op_a;
  logic signed [rtnh_pkg::OpBW-1:0] op_b;
  logic                          mac_done;
  logic signed [AW-1:0]          mac_acc;

  // Decision and divider signals
  logic signed [AW-1:0]          eps_w;
  logic signed [AW:0]            uv;
  logic signed [AW:0]            det_x;
  logic                          front, back, front_ok, back_ok, hit_ok;
  logic [AW-1:0]                 tn_abs, det_abs;
  logic                          div_done, div_ovf;
  logic [rtnh_pkg::QuoW-1:0]     div_quo;
  logic signed [CW-1:0]          t_val;

  // --------------------------------------------------------------------------
  // Configuration: always ready; writes beyond the register list are dropped.
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      dir_q[0] <= 32'h0001_0000;
      dir_q[1] <= '0;
      dir_q[2] <= '0;
      eps_q    <= 16'd7;
    end else if (cfg_valid_i) begin
      case (rtnh_pkg::cfg_idx_e'(cfg_index_i))
        rtnh_pkg::CFG_ORIGIN_X: org_q[0] <= cfg_data_i;
        rtnh_pkg::CFG_ORIGIN_Y: org_q[1] <= cfg_data_i;
        rtnh_pkg::CFG_ORIGIN_Z: org_q[2] <= cfg_data_i;
        rtnh_pkg::CFG_DIR_X:    dir_q[0] <= cfg_data_i;
        rtnh_pkg::CFG_DIR_Y:    dir_q[1] <= cfg_data_i;
        rtnh_pkg::CFG_DIR_Z:    dir_q[2] <= cfg_data_i;
        rtnh_pkg::CFG_EPSILON:  eps_q    <= cfg_data_i[rtnh_pkg::EpsW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rtnh_pkg::ST_IDLE:      if (s_axis_tvalid_i) state_d = rtnh_pkg::ST_MAC_ISSUE;
      rtnh_pkg::ST_MAC_ISSUE: state_d = rtnh_pkg::ST_MAC_WAIT;
      rtnh_pkg::ST_MAC_WAIT: begin
        if (mac_done) begin
          state_d = (step_q == rtnh_pkg::LastStep) ? rtnh_pkg::ST_DECIDE
                                                   : rtnh_pkg::ST_MAC_ISSUE;
        end
      end
      rtnh_pkg::ST_DECIDE:    state_d = hit_ok ? rtnh_pkg::ST_DIV_WAIT : rtnh_pkg::ST_UPDATE;
      rtnh_pkg::ST_DIV_WAIT:  if (div_done) state_d = rtnh_pkg::ST_UPDATE;
      rtnh_pkg::ST_UPDATE:    state_d = final_q ? rtnh_pkg::ST_EMIT : rtnh_pkg::ST_IDLE;
      rtnh_pkg::ST_EMIT:      if (out_free) state_d = rtnh_pkg::ST_IDLE;
      default:                state_d = rtnh_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    load_item   = 1'b0;
    mac_issue   = 1'b0;
    mac_capture = 1'b0;
    div_start   = 1'b0;
    do_update   = 1'b0;
    do_emit     = 1'b0;
    case (state_q)
      rtnh_pkg::ST_IDLE:      load_item   = s_axis_tvalid_i;
      rtnh_pkg::ST_MAC_ISSUE: mac_issue   = 1'b1;
      rtnh_pkg::ST_MAC_WAIT:  mac_capture = mac_done;
      rtnh_pkg::ST_DECIDE:    div_start   = hit_ok;
      rtnh_pkg::ST_DIV_WAIT:  ;
      rtnh_pkg::ST_UPDATE:    do_update   = 1'b1;
      rtnh_pkg::ST_EMIT:      do_emit     = out_free;
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == rtnh_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtnh_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load_item) begin
        step_q <= '0;
      end else if (mac_capture) begin
        step_q <= step_q + 5'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Capture the triangle as edges and origin offset.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (load_item) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= $signed({s_axis_tdata_i[(3+k)*CW+CW-1], s_axis_tdata_i[(3+k)*CW +: CW]})
                 - $signed({s_axis_tdata_i[k*CW+CW-1], s_axis_tdata_i[k*CW +: CW]});
        e2_q[k] <= $signed({s_axis_tdata_i[(6+k)*CW+CW-1], s_axis_tdata_i[(6+k)*CW +: CW]})
                 - $signed({s_axis_tdata_i[k*CW+CW-1], s_axis_tdata_i[k*CW +: CW]});
        s_q[k]  <= $signed({org_q[k][CW-1], org_q[k]})
                 - $signed({s_axis_tdata_i[k*CW+CW-1], s_axis_tdata_i[k*CW +: CW]});
      end
      final_q <= s_axis_tlast_i;
    end
  end

  // --------------------------------------------------------------------------
  // Operand selection for the shared MAC
  // --------------------------------------------------------------------------
  assign step = rtnh_pkg::step_info(step_q);

  always_comb begin
    case (step.a_vec)
      rtnh_pkg::VEC_D:  op_a = $signed({{2{dir_q[step.a_idx][CW-1]}}, dir_q[step.a_idx]});
      rtnh_pkg::VEC_E1: op_a = $signed({e1_q[step.a_idx][EW-1], e1_q[step.a_idx]});
      rtnh_pkg::VEC_E2: op_a = $signed({e2_q[step.a_idx][EW-1], e2_q[step.a_idx]});
      rtnh_pkg::VEC_S:  op_a = $signed({s_q[step.a_idx][EW-1], s_q[step.a_idx]});
      default:          op_a = '0;
    endcase
  end

  always_comb begin
    case (step.b_vec)
      rtnh_pkg::VEC_E1: op_b = $signed({{(rtnh_pkg::OpBW-EW){e1_q[step.b_idx][EW-1]}},
                                         e1_q[step.b_idx]});
      rtnh_pkg::VEC_E2: op_b = $signed({{(rtnh_pkg::OpBW-EW){e2_q[step.b_idx][EW-1]}},
                                         e2_q[step.b_idx]});
      rtnh_pkg::VEC_R:  op_b = r_q[step.b_idx];
      rtnh_pkg::VEC_Q:  op_b = q_q[step.b_idx];
      default:          op_b = '0;
    endcase
  end

  assign mac_ctl.start = mac_issue;
  assign mac_ctl.first = step.first;
  assign mac_ctl.sub   = step.sub;

  rtnh_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  // Store the finished cross component or dot product.
  always_ff @(posedge clk_i) begin
    if (mac_capture) begin
      case (step.dst)
        rtnh_pkg::DST_R:   r_q[step.dst_idx] <= mac_acc[rtnh_pkg::OpBW-1:0];
        rtnh_pkg::DST_Q:   q_q[step.dst_idx] <= mac_acc[rtnh_pkg::OpBW-1:0];
        rtnh_pkg::DST_DET: det_q <= mac_acc;
        rtnh_pkg::DST_U:   u_q   <= mac_acc;
        rtnh_pkg::DST_V:   v_q   <= mac_acc;
        rtnh_pkg::DST_TN:  tn_q  <= mac_acc;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Facing and barycentric test; both facings count.
  // --------------------------------------------------------------------------
  assign eps_w = $signed({{(AW-rtnh_pkg::EpsW-32){1'b0}}, eps_q, 32'b0});
  assign uv    = $signed({u_q[AW-1], u_q}) + $signed({v_q[AW-1], v_q});
  assign det_x = $signed({det_q[AW-1], det_q});
  assign front = det_q > eps_w;
  assign back  = det_q < -eps_w;

  assign front_ok = !(u_q < 0) && !(u_q > det_q) && !(v_q < 0) && !(uv > det_x);
  assign back_ok  = !(u_q > 0) && !(u_q < det_q) && !(v_q > 0) && !(uv < det_x);
  assign hit_ok   = (front && front_ok) || (back && back_ok);

  assign tn_abs  = tn_q[AW-1]  ? AW'(-tn_q)  : AW'(tn_q);
  assign det_abs = det_q[AW-1] ? AW'(-det_q) : AW'(det_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (state_q == rtnh_pkg::ST_DECIDE) begin
      hit_q <= hit_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      negq_q <= tn_q[AW-1] ^ det_q[AW-1];
    end
  end

  // Quotient of |tn| * 2^16 by |det|.
  rtnh_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_hi_i (tn_abs[AW-1:16]),
    .num_lo_i ({tn_abs[15:0], 16'b0}),
    .den_i    (det_abs),
    .done_o   (div_done),
    .ovf_o    (div_ovf),
    .quo_o    (div_quo)
  );

  // Saturate the signed quotient to 32 bits.
  always_comb begin
    if (div_ovf || div_quo[rtnh_pkg::QuoW-1]) begin
      t_val = negq_q ? rtnh_pkg::T32Min : rtnh_pkg::T32Max;
    end else begin
      t_val = negq_q ? -$signed(div_quo) : $signed(div_quo);
    end
  end

  // --------------------------------------------------------------------------
  // Running minimum; zero means no hit, so a zero distance is dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nearest_q <= '0;
    end else if (do_update) begin
      if (hit_q && (t_val != 0) && ((nearest_q == 0) || (nearest_q > t_val))) begin
        nearest_q <= t_val;
      end
    end else if (do_emit) begin
      nearest_q <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: hold the result until the transaction completes.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_emit) begin
      out_hit_q  <= (nearest_q != 0);
      out_dist_q <= (nearest_q == rtnh_pkg::T32Min) ? rtnh_pkg::T32Max : -nearest_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_dist_q;
  assign m_axis_tuser_o  = out_hit_q;

endmodule

`default_nettype wire

// File: src/rtnh_mac.sv
// ----------------------------------------------------------------------------
// rtnh_mac: digit-serial signed multiply-accumulate
// Multiplies a short signed operand by a long signed operand one 16-bit digit
// per cycle and adds or subtracts the product into a running accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module rtnh_mac (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rtnh_pkg::mac_ctl_t                ctl_i,
  input  wire logic signed [rtnh_pkg::OpAW-1:0]  a_i,
  input  wire logic signed [rtnh_pkg::OpBW-1:0]  b_i,
  output logic                                   done_o,
  output logic signed [rtnh_pkg::AccW-1:0]       acc_o
);

  logic                                   busy_q;
  logic                                   done_q;
  logic [2:0]                             cnt_q;
  logic signed [rtnh_pkg::OpAW-1:0]       a_q;
  logic [rtnh_pkg::OpBExtW-1:0]           b_q;
  logic signed [rtnh_pkg::AccW-1:0]       acc_q;
  logic signed [rtnh_pkg::DigitW:0]       digit;
  logic signed [rtnh_pkg::ProdW-1:0]      prod;
  logic signed [rtnh_pkg::AccW-1:0]       prod_ext;
  logic signed [rtnh_pkg::AccW-1:0]       prod_sh;

  // Lower digits are unsigned, the top digit carries the sign.
  always_comb begin
    case (cnt_q)
      3'd0: digit = {1'b0, b_q[15:0]};
      3'd1: digit = {1'b0, b_q[31:16]};
      3'd2: digit = {1'b0, b_q[47:32]};
      3'd3: digit = {1'b0, b_q[63:48]};
      3'd4: digit = {b_q[79], b_q[79:64]};
      default: digit = '0;
    endcase
  end

  assign prod     = a_q * digit;
  assign prod_ext = {{(rtnh_pkg::AccW-rtnh_pkg::ProdW){prod[rtnh_pkg::ProdW-1]}}, prod};
  assign prod_sh  = prod_ext <<< {cnt_q, 4'b0000};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'(rtnh_pkg::MacDigits - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      a_q <= ctl_i.sub ? -a_i : a_i;
      b_q <= {{(rtnh_pkg::OpBExtW-rtnh_pkg::OpBW){b_i[rtnh_pkg::OpBW-1]}}, b_i};
      if (ctl_i.first) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      acc_q <= acc_q + prod_sh;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

// File: src/rtnh_div.sv
// ----------------------------------------------------------------------------
// rtnh_div: restoring unsigned divider for the hit distance
// Flags a quotient of 2^32 or more up front, else develops 32 quotient bits,
// one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rtnh_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [rtnh_pkg::NumHiW-1:0]       num_hi_i,
  input  wire logic [rtnh_pkg::QuoW-1:0]         num_lo_i,
  input  wire logic [rtnh_pkg::AccW-1:0]         den_i,
  output logic                                   done_o,
  output logic                                   ovf_o,
  output logic [rtnh_pkg::QuoW-1:0]              quo_o
);

  logic                          busy_q;
  logic                          done_q;
  logic                          ovf_q;
  logic [5:0]                    cnt_q;
  logic [rtnh_pkg::AccW-1:0]     den_q;
  logic [rtnh_pkg::AccW-1:0]     rem_q;
  logic [rtnh_pkg::QuoW-1:0]     lo_q;
  logic [rtnh_pkg::QuoW-1:0]     quo_q;
  logic [rtnh_pkg::AccW:0]       rem_sh;
  logic [rtnh_pkg::AccW:0]       rem_diff;
  logic                          fits;
  logic                          ovf_now;

  assign ovf_now  = {{(rtnh_pkg::AccW-rtnh_pkg::NumHiW){1'b0}}, num_hi_i} >= den_i;
  assign rem_sh   = {rem_q, lo_q[rtnh_pkg::QuoW-1]};
  assign rem_diff = rem_sh - {1'b0, den_q};
  assign fits     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= !ovf_now;
      done_q <= ovf_now;
      ovf_q  <= ovf_now;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'(rtnh_pkg::QuoW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= {{(rtnh_pkg::AccW-rtnh_pkg::NumHiW){1'b0}}, num_hi_i};
      lo_q  <= num_lo_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_diff[rtnh_pkg::AccW-1:0] : rem_sh[rtnh_pkg::AccW-1:0];
      lo_q  <= {lo_q[rtnh_pkg::QuoW-2:0], 1'b0};
      quo_q <= {quo_q[rtnh_pkg::QuoW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// File: tb/ray_triangle_nearest_hit_tb.sv
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_tb: self-checking bench for the nearest-hit block
// Triangles are streamed in runs for several ray settings. An exact-width
// predictor works out the nearest hit of each run, and every result
// transaction is checked against it. Both stream sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_triangle_nearest_hit_tb;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 250;   // one triangle with a hit, plus margin
  localparam int unsigned HoldCycles    = 1500;

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    logic [rtnh_pkg::ItemW-1:0] corners;   // a.xyz, b.xyz, c.xyz from the lowest bits up
    logic                       last;
  } triangle_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] neg_dist;
  } nearest_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [rtnh_pkg::CfgIdxW-1:0] cfg_index;
  logic [rtnh_pkg::CoordW-1:0] cfg_data;
  logic s_valid, s_ready, s_last;
  logic [rtnh_pkg::ItemW-1:0] s_data;
  logic m_valid, m_ready, m_user;
  logic [rtnh_pkg::CoordW-1:0] m_data;

  ray_triangle_nearest_hit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  // Predictor copy of the ray registers and the running minimum.
  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_dir [3];
  logic [rtnh_pkg::EpsW-1:0] ray_eps;
  logic signed [31:0] nearest_t_min;

  triangle_t pending_tris[$];
  nearest_t  expected_nearest[$];
  int unsigned mismatches = 0;
  int unsigned src_idle_pct = 0, sink_stall_pct = 0;
  bit sink_hold = 1'b0;
  bit s_taken = 1'b0;
  bit any_xfer;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // Full-width Moller-Trumbore test; fold the hit into the running minimum.
  function automatic void predict_triangle(input triangle_t tr);
    wide_t a[3], e1[3], e2[3], s[3], d[3], r[3], q[3];
    wide_t det, u, v, tn, eps, quo;
    logic signed [31:0] t;
    logic signed [32:0] neg;
    bit hit;
    for (int k = 0; k < 3; k++) begin
      a[k]  = wide_t'($signed(tr.corners[32*k +: 32]));
      e1[k] = wide_t'($signed(tr.corners[32*(k+3) +: 32])) - a[k];
      e2[k] = wide_t'($signed(tr.corners[32*(k+6) +: 32])) - a[k];
      d[k]  = wide_t'(ray_dir[k]);
      s[k]  = wide_t'(ray_org[k]) - a[k];
    end
    r[0] = d[1]*e2[2] - d[2]*e2[1];
    r[1] = d[2]*e2[0] - d[0]*e2[2];
    r[2] = d[0]*e2[1] - d[1]*e2[0];
    q[0] = s[1]*e1[2] - s[2]*e1[1];
    q[1] = s[2]*e1[0] - s[0]*e1[2];
    q[2] = s[0]*e1[1] - s[1]*e1[0];
    det = e1[0]*r[0] + e1[1]*r[1] + e1[2]*r[2];
    u   = s[0]*r[0] + s[1]*r[1] + s[2]*r[2];
    v   = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
    tn  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
    eps = wide_t'($signed({1'b0, ray_eps, 32'h0}));
    hit = 1'b0;
    if (det > eps) begin
      hit = !(u < 0 || u > det || v < 0 || u + v > det);
    end else if (det < -eps) begin
      hit = !(u > 0 || u < det || v > 0 || u + v < det);
    end
    if (hit) begin
      quo = (tn <<< 16) / det;   // truncates toward zero
      if (quo < wide_t'(rtnh_pkg::T32Min)) t = rtnh_pkg::T32Min;
      else if (quo > wide_t'(rtnh_pkg::T32Max)) t = rtnh_pkg::T32Max;
      else t = quo[31:0];
      if (t != 0 && (nearest_t_min == 0 || nearest_t_min > t)) nearest_t_min = t;
    end
    if (tr.last) begin
      neg = -33'(nearest_t_min);
      if (neg > 33'sd2147483647) neg = 33'sd2147483647;
      expected_nearest.push_back('{hit: nearest_t_min != 0, neg_dist: neg[31:0]});
      nearest_t_min = '0;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // Triangle driver: retire on the accepting edge, change inputs on the falling edge.
  always @(posedge clk) begin
    if (s_valid && s_ready) begin
      predict_triangle(pending_tris.pop_front());
      s_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!s_valid || s_taken) && pending_tris.size() > 0 &&
        $urandom_range(99) >= src_idle_pct) begin
      s_valid <= 1'b1;
      s_data  <= pending_tris[0].corners;
      s_last  <= pending_tris[0].last;
    end else if (s_taken) begin
      s_valid <= 1'b0;
    end
    s_taken = 1'b0;
    m_ready <= !sink_hold && $urandom_range(99) >= sink_stall_pct;
  end

  // Result monitor: check each transaction against the oldest expectation.
  always @(posedge clk) begin
    if (m_valid && m_ready) begin
      if (expected_nearest.size() == 0) begin
        report_mismatch("unexpected result", {31'b0, m_user}, 32'b0);
      end else begin
        if (m_user !== expected_nearest[0].hit)
          report_mismatch("hit_found", {31'b0, m_user}, {31'b0, expected_nearest[0].hit});
        if (m_data !== expected_nearest[0].neg_dist)
          report_mismatch("negated_distance", m_data, expected_nearest[0].neg_dist);
        void'(expected_nearest.pop_front());
      end
    end
  end

  // Watchdog: count cycles with no transaction on any channel.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    any_xfer = (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready);
    quiet_cycles <= any_xfer ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(input rtnh_pkg::cfg_idx_e idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rtnh_pkg::CFG_ORIGIN_X: ray_org[0] = value;
      rtnh_pkg::CFG_ORIGIN_Y: ray_org[1] = value;
      rtnh_pkg::CFG_ORIGIN_Z: ray_org[2] = value;
      rtnh_pkg::CFG_DIR_X:    ray_dir[0] = value;
      rtnh_pkg::CFG_DIR_Y:    ray_dir[1] = value;
      rtnh_pkg::CFG_DIR_Z:    ray_dir[2] = value;
      rtnh_pkg::CFG_EPSILON:  ray_eps    = value[rtnh_pkg::EpsW-1:0];
      default: ;  // unused index: ignored
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, input logic [15:0] eps);
    write_reg(rtnh_pkg::CFG_ORIGIN_X, ox);
    write_reg(rtnh_pkg::CFG_ORIGIN_Y, oy);
    write_reg(rtnh_pkg::CFG_ORIGIN_Z, oz);
    write_reg(rtnh_pkg::CFG_DIR_X, dx);
    write_reg(rtnh_pkg::CFG_DIR_Y, dy);
    write_reg(rtnh_pkg::CFG_DIR_Z, dz);
    write_reg(rtnh_pkg::CFG_EPSILON, {16'h0, eps});
  endtask

  // Hold until every triangle is taken and every result checked, then let
  // a trailing non-final triangle finish before touching the registers.
  task automatic drain();
    while (pending_tris.size() > 0 || s_valid || expected_nearest.size() > 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic triangle_t pack_tri(input logic [31:0] c[9], input logic last);
    triangle_t tr;
    for (int k = 0; k < 9; k++) tr.corners[32*k +: 32] = c[k];
    tr.last = last;
    return tr;
  endfunction

  // Triangle whose centroid lies on the ray at a random parameter.
  function automatic triangle_t hit_tri(input logic last, input bit flip);
    logic [31:0] c[9];
    logic signed [63:0] t, p, o1, o2;
    t = $signed(64'($urandom_range(32'h40000))) - 64'sh10000;
    for (int k = 0; k < 3; k++) begin
      p  = 64'(ray_org[k]) + ((t * 64'(ray_dir[k])) >>> 16);
      o1 = $signed(64'($urandom_range(32'h1fffff))) - 64'sh100000;
      o2 = $signed(64'($urandom_range(32'h1fffff))) - 64'sh100000;
      c[k]     = 32'(p + o1);
      c[k + 3] = 32'(flip ? p - o1 - o2 : p + o2);
      c[k + 6] = 32'(flip ? p + o2 : p - o1 - o2);
    end
    return pack_tri(c, last);
  endfunction

  function automatic triangle_t noise_tri(input logic last);
    logic [31:0] c[9];
    for (int k = 0; k < 9; k++) c[k] = $urandom();
    return pack_tri(c, last);
  endfunction

  function automatic triangle_t axis_tri(input int x, input int y0, input int z0,
                                         input int sz, input bit flip, input logic last);
    logic [31:0] c[9];
    int one = 65536;
    c = '{x*one, y0*one, z0*one, x*one, (y0+sz)*one, z0*one, x*one, y0*one, (z0+sz)*one};
    if (flip) begin
      c[3] = x*one; c[4] = y0*one; c[5] = (z0+sz)*one;
      c[6] = x*one; c[7] = (y0+sz)*one; c[8] = z0*one;
    end
    return pack_tri(c, last);
  endfunction

  task automatic queue_random(input int unsigned n_items);
    int unsigned done, run_len, sel;
    done = 0;
    while (done < n_items) begin
      run_len = $urandom_range(6, 1);
      for (int i = 0; i < run_len; i++) begin
        sel = $urandom_range(99);
        if (sel < 75) pending_tris.push_back(hit_tri(i == run_len - 1, 1'($urandom_range(1))));
        else if (sel < 90) pending_tris.push_back(noise_tri(i == run_len - 1));
        else pending_tris.push_back(noise_tri(1'($urandom_range(1))));
        done++;
      end
    end
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode % 4)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 50; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 50; end
      default: begin src_idle_pct = 14; sink_stall_pct = 14; end
    endcase
  endtask

  initial begin
    logic [31:0] big[9], tiny[9];
    rst_n = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    s_valid = 1'b0; s_data = '0; s_last = 1'b0; m_ready = 1'b0;
    ray_org = '{0, 0, 0}; ray_dir = '{32'sh10000, 0, 0};
    ray_eps = 16'd7; nearest_t_min = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset ray along +x.
    pending_tris.push_back(axis_tri(5, -1, -1, 3, 0, 1));      // back-facing hit at 5
    pending_tris.push_back(axis_tri(5, -1, -1, 3, 1, 1));      // front-facing hit
    pending_tris.push_back(axis_tri(-3, -1, -1, 3, 0, 1));     // hit behind origin
    pending_tris.push_back(axis_tri(0, -1, -1, 3, 0, 1));      // zero distance ignored
    pending_tris.push_back(axis_tri(9, -1, -1, 3, 0, 0));      // keep nearest of a run
    pending_tris.push_back(axis_tri(2, -1, -1, 3, 1, 0));
    pending_tris.push_back(axis_tri(7, -1, -1, 3, 0, 1));
    pending_tris.push_back(axis_tri(4, 1, 1, 3, 0, 1));        // miss, u < 0
    pending_tris.push_back(axis_tri(4, 0, 0, 3, 0, 1));        // hit on a corner
    pending_tris.push_back(axis_tri(4, -3, -3, 3, 0, 1));      // miss beyond the far edge
    begin
      logic [31:0] c[9];
      c = '{0, 0, 32'h50000, 32'h50000, 0, 0, 0, 0, 32'hfffb0000};  // parallel, y = 0
      pending_tris.push_back(pack_tri(c, 1));
    end
    big = '{default: 32'h7fffffff}; tiny = '{default: 32'h80000000};
    pending_tris.push_back(pack_tri(big, 0));
    pending_tris.push_back(pack_tri(tiny, 1));
    pending_tris.push_back(noise_tri(0));
    pending_tris.push_back(noise_tri(1));
    drain();

    // Tiny direction and a far triangle: distance saturates high and low.
    set_ray(0, 0, 0, 1, 0, 0, 0);
    pending_tris.push_back(axis_tri(30000, -1, -1, 3, 0, 1));
    pending_tris.push_back(axis_tri(-30000, -1, -1, 3, 1, 1));
    pending_tris.push_back(axis_tri(100, -1, -1, 3, 0, 1));
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      set_idling(ph);
      case (ph)
        0: set_ray(0, 0, 0, 32'h10000, 0, 0, 7);
        1: set_ray(32'h30000, 32'hfffe0000, 32'h8000, 32'h9000, 32'h4000, 32'hffff3000, 0);
        2: set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff, 32'h80000000, 16'hffff);
        3: set_ray($urandom_range(32'hfffff), $urandom_range(32'hfffff), 0,
                   $urandom_range(32'h3ffff), $urandom_range(32'h3ffff), 32'h10000, 16'hffff);
        default: set_ray($urandom(), $urandom(), $urandom() >> 8,
                         $urandom() >> ($urandom_range(20)), $urandom() >> 12,
                         $urandom(), 16'($urandom_range(16'hffff)));
      endcase
      if (ph == 4) begin
        write_reg(rtnh_pkg::CFG_UNUSED, $urandom());
        set_ray(32'h20000, 32'h10000, 32'hffff0000, 32'h8000, 32'hffffc000, 32'h2000, 3);
      end
      queue_random(78);
      if (ph == 5) begin
        // Hold off the receiver so that results back up into the block.
        fork
          begin
            sink_hold = 1'b1;
            repeat (HoldCycles) @(posedge clk);
            sink_hold = 1'b0;
          end
        join_none
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
